// ===== hdl/yrc_pkg.sv =====
// ----------------------------------------------------------------------------
// yrc_pkg
// Shared constants, types and helper functions for the YUYV to RGB888
// color conversion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package yrc_pkg;

  // Default number of fraction bits in the color coefficients
  localparam int COEF_FRAC_BITS_DEF = 12;

  // Byte widths of the stream fields
  localparam int PIX_W  = 8;
  localparam int IN_W   = 4 * PIX_W;
  localparam int OUT_W  = 6 * PIX_W;

  // Integer part of a channel after the fixed-point shift, signed
  localparam int CHAN_W = 11;

  // Conversion coefficients in millionths
  localparam longint CR_MICRO  = 64'd1370705;
  localparam longint CGV_MICRO = 64'd698001;
  localparam longint CGU_MICRO = 64'd337633;
  localparam longint CB_MICRO  = 64'd1732446;
  localparam longint Q_DIV     = 64'd1000000;
  localparam longint Q_HALF    = 64'd500000;

  // Output scale 220/256
  localparam logic [PIX_W-1:0] SCALE_MUL = 8'd220;

  // Two RGB pixels of one macropixel, already clamped
  typedef struct packed {
    logic [PIX_W-1:0] blue1;
    logic [PIX_W-1:0] green1;
    logic [PIX_W-1:0] red1;
    logic [PIX_W-1:0] blue0;
    logic [PIX_W-1:0] green0;
    logic [PIX_W-1:0] red0;
  } rgb_pair_t;

  // Round a coefficient given in millionths to nearest at 2^frac
  function automatic longint coef_q(input longint micro, input int frac);
    longint scaled;
    scaled = micro <<< frac;
    return (scaled + Q_HALF) / Q_DIV;
  endfunction

  // Clamp a signed channel value to 0..255
  function automatic logic [PIX_W-1:0] clamp_byte(input logic signed [CHAN_W-1:0] c);
    logic [PIX_W-1:0] res;
    if (c[CHAN_W-1]) begin
      res = '0;
    end else if (|c[CHAN_W-2:PIX_W]) begin
      res = '1;
    end else begin
      res = c[PIX_W-1:0];
    end
    return res;
  endfunction

  // Scale a byte by 220/256, floored
  function automatic logic [PIX_W-1:0] scale_byte(input logic [PIX_W-1:0] c);
    logic [2*PIX_W-1:0] prod;
    prod = {{PIX_W{1'b0}}, c} * {{PIX_W{1'b0}}, SCALE_MUL};
    return prod[2*PIX_W-1:PIX_W];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/yuyv_to_rgb888_converter.sv =====
// ----------------------------------------------------------------------------
// yuyv_to_rgb888_converter
// YUYV 4:2:2 macropixel to two RGB888 pixels, clamped and scaled by 220/256.
// ----------------------------------------------------------------------------
// One macropixel is taken every clock while the output side does not stall,
// and its two RGB pixels pass through four register stages (chroma
// products, channel sums, floor and clamp, 220/256 scale); the last stage
// is the output register. Each stage refills as soon as its content moves
// on, so a stall on the output side holds each full stage in place back to
// the first empty one, and the input takes a new request in any cycle in
// which some stage, its own included, has room. tlast rides along with its
// macropixel. Nothing is stored between macropixels and reset only empties
// the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module yuyv_to_rgb888_converter #(
  parameter int COEF_FRAC_BITS = yrc_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output      logic                        s_tready,
  input  wire logic [yrc_pkg::IN_W-1:0]    s_tdata,   // y0, u, y1, v
  input  wire logic                        s_tlast,   // frame_end
  output      logic                        m_tvalid,
  input  wire logic                        m_tready,
  output      logic [yrc_pkg::OUT_W-1:0]   m_tdata,   // red0, green0, blue0, red1, green1, blue1
  output      logic                        m_tlast    // frame_end_out
);

  localparam int PW     = yrc_pkg::PIX_W;
  localparam int PROD_W = COEF_FRAC_BITS + 10;
  localparam int ACC_W  = COEF_FRAC_BITS + yrc_pkg::CHAN_W;

  // Stage 1 to stage 2
  logic                     mul_valid;
  logic                     sum_ready;
  logic [PW-1:0]            mul_y0;
  logic [PW-1:0]            mul_y1;
  logic                     mul_last;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_gv;
  logic signed [PROD_W-1:0] prod_gu;
  logic signed [PROD_W-1:0] prod_b;

  // Stage 2 to stage 3
  logic                     sum_valid;
  logic                     sat_ready;
  logic                     sum_last;
  logic signed [ACC_W-1:0]  acc_r0;
  logic signed [ACC_W-1:0]  acc_g0;
  logic signed [ACC_W-1:0]  acc_b0;
  logic signed [ACC_W-1:0]  acc_r1;
  logic signed [ACC_W-1:0]  acc_g1;
  logic signed [ACC_W-1:0]  acc_b1;

  // Stage 3 to stage 4
  logic                     sat_valid;
  logic                     scale_ready;
  logic                     sat_last;
  yrc_pkg::rgb_pair_t       sat_pix;

  // Output
  yrc_pkg::rgb_pair_t       out_pix;

  yrc_mul #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_mul (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .y0          (s_tdata[PW-1:0]),
    .u           (s_tdata[2*PW-1:PW]),
    .y1          (s_tdata[3*PW-1:2*PW]),
    .v           (s_tdata[4*PW-1:3*PW]),
    .frame_end   (s_tlast),
    .out_valid   (mul_valid),
    .out_ready   (sum_ready),
    .y0_q        (mul_y0),
    .y1_q        (mul_y1),
    .frame_end_q (mul_last),
    .prod_r      (prod_r),
    .prod_gv     (prod_gv),
    .prod_gu     (prod_gu),
    .prod_b      (prod_b)
  );

  yrc_sum #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_sum (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (mul_valid),
    .in_ready    (sum_ready),
    .y0          (mul_y0),
    .y1          (mul_y1),
    .frame_end   (mul_last),
    .prod_r      (prod_r),
    .prod_gv     (prod_gv),
    .prod_gu     (prod_gu),
    .prod_b      (prod_b),
    .out_valid   (sum_valid),
    .out_ready   (sat_ready),
    .frame_end_q (sum_last),
    .acc_r0      (acc_r0),
    .acc_g0      (acc_g0),
    .acc_b0      (acc_b0),
    .acc_r1      (acc_r1),
    .acc_g1      (acc_g1),
    .acc_b1      (acc_b1)
  );

  yrc_sat #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_sat (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (sum_valid),
    .in_ready    (sat_ready),
    .frame_end   (sum_last),
    .acc_r0      (acc_r0),
    .acc_g0      (acc_g0),
    .acc_b0      (acc_b0),
    .acc_r1      (acc_r1),
    .acc_g1      (acc_g1),
    .acc_b1      (acc_b1),
    .out_valid   (sat_valid),
    .out_ready   (scale_ready),
    .frame_end_q (sat_last),
    .pix         (sat_pix)
  );

  yrc_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (sat_valid),
    .in_ready    (scale_ready),
    .frame_end   (sat_last),
    .pix         (sat_pix),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .frame_end_q (m_tlast),
    .pix_q       (out_pix)
  );

  // Pack the pixels, first channel in the lowest byte
  assign m_tdata = {out_pix.blue1, out_pix.green1, out_pix.red1,
                    out_pix.blue0, out_pix.green0, out_pix.red0};

endmodule

`default_nettype wire

// ===== hdl/yrc_mul.sv =====
// ----------------------------------------------------------------------------
// yrc_mul
// First pipeline stage: remove the chroma offset and form the four
// coefficient products shared by both pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module yrc_mul #(
  parameter int COEF_FRAC_BITS = yrc_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output      logic                              in_ready,
  input  wire logic [yrc_pkg::PIX_W-1:0]         y0,
  input  wire logic [yrc_pkg::PIX_W-1:0]         u,
  input  wire logic [yrc_pkg::PIX_W-1:0]         y1,
  input  wire logic [yrc_pkg::PIX_W-1:0]         v,
  input  wire logic                              frame_end,
  output      logic                              out_valid,
  input  wire logic                              out_ready,
  output      logic [yrc_pkg::PIX_W-1:0]         y0_q,
  output      logic [yrc_pkg::PIX_W-1:0]         y1_q,
  output      logic                              frame_end_q,
  output      logic signed [COEF_FRAC_BITS+9:0]  prod_r,
  output      logic signed [COEF_FRAC_BITS+9:0]  prod_gv,
  output      logic signed [COEF_FRAC_BITS+9:0]  prod_gu,
  output      logic signed [COEF_FRAC_BITS+9:0]  prod_b
);

  localparam int COEF_W = COEF_FRAC_BITS + 2;
  localparam int PROD_W = COEF_W + yrc_pkg::PIX_W;

  localparam logic signed [COEF_W-1:0] CR =
    COEF_W'(yrc_pkg::coef_q(yrc_pkg::CR_MICRO, COEF_FRAC_BITS));
  localparam logic signed [COEF_W-1:0] CGV =
    COEF_W'(yrc_pkg::coef_q(yrc_pkg::CGV_MICRO, COEF_FRAC_BITS));
  localparam logic signed [COEF_W-1:0] CGU =
    COEF_W'(yrc_pkg::coef_q(yrc_pkg::CGU_MICRO, COEF_FRAC_BITS));
  localparam logic signed [COEF_W-1:0] CB =
    COEF_W'(yrc_pkg::coef_q(yrc_pkg::CB_MICRO, COEF_FRAC_BITS));

  logic                      valid;
  logic signed [yrc_pkg::PIX_W-1:0] du;
  logic signed [yrc_pkg::PIX_W-1:0] dv;
  logic signed [PROD_W-1:0]  prod_r_next;
  logic signed [PROD_W-1:0]  prod_gv_next;
  logic signed [PROD_W-1:0]  prod_gu_next;
  logic signed [PROD_W-1:0]  prod_b_next;

  // Subtract 128 by flipping the top bit
  assign du = signed'({~u[yrc_pkg::PIX_W-1], u[yrc_pkg::PIX_W-2:0]});
  assign dv = signed'({~v[yrc_pkg::PIX_W-1], v[yrc_pkg::PIX_W-2:0]});

  // Coefficient products, both operands sign extended to the product width
  assign prod_r_next  = PROD_W'(CR)  * PROD_W'(dv);
  assign prod_gv_next = PROD_W'(CGV) * PROD_W'(dv);
  assign prod_gu_next = PROD_W'(CGU) * PROD_W'(du);
  assign prod_b_next  = PROD_W'(CB)  * PROD_W'(du);

  // Advance when this stage is empty or its content moves on
  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Capture payload on each accepted request
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      y0_q        <= y0;
      y1_q        <= y1;
      frame_end_q <= frame_end;
      prod_r      <= prod_r_next;
      prod_gv     <= prod_gv_next;
      prod_gu     <= prod_gu_next;
      prod_b      <= prod_b_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/yrc_sum.sv =====
// ----------------------------------------------------------------------------
// yrc_sum
// Second pipeline stage: add the scaled luma to the chroma products and
// form the six fixed-point channel sums.
// ----------------------------------------------------------------------------
`default_nettype none

module yrc_sum #(
  parameter int COEF_FRAC_BITS = yrc_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output      logic                              in_ready,
  input  wire logic [yrc_pkg::PIX_W-1:0]         y0,
  input  wire logic [yrc_pkg::PIX_W-1:0]         y1,
  input  wire logic                              frame_end,
  input  wire logic signed [COEF_FRAC_BITS+9:0]  prod_r,
  input  wire logic signed [COEF_FRAC_BITS+9:0]  prod_gv,
  input  wire logic signed [COEF_FRAC_BITS+9:0]  prod_gu,
  input  wire logic signed [COEF_FRAC_BITS+9:0]  prod_b,
  output      logic                              out_valid,
  input  wire logic                              out_ready,
  output      logic                              frame_end_q,
  output      logic signed [COEF_FRAC_BITS+10:0] acc_r0,
  output      logic signed [COEF_FRAC_BITS+10:0] acc_g0,
  output      logic signed [COEF_FRAC_BITS+10:0] acc_b0,
  output      logic signed [COEF_FRAC_BITS+10:0] acc_r1,
  output      logic signed [COEF_FRAC_BITS+10:0] acc_g1,
  output      logic signed [COEF_FRAC_BITS+10:0] acc_b1
);

  localparam int ACC_W = COEF_FRAC_BITS + yrc_pkg::CHAN_W;
  localparam int PAD_W = ACC_W - COEF_FRAC_BITS - yrc_pkg::PIX_W;

  logic                     valid;
  logic signed [ACC_W-1:0]  ys0;
  logic signed [ACC_W-1:0]  ys1;
  logic signed [ACC_W-1:0]  ext_r;
  logic signed [ACC_W-1:0]  ext_gv;
  logic signed [ACC_W-1:0]  ext_gu;
  logic signed [ACC_W-1:0]  ext_b;

  // Luma in fixed point, products sign extended
  assign ys0    = signed'({{PAD_W{1'b0}}, y0, {COEF_FRAC_BITS{1'b0}}});
  assign ys1    = signed'({{PAD_W{1'b0}}, y1, {COEF_FRAC_BITS{1'b0}}});
  assign ext_r  = ACC_W'(prod_r);
  assign ext_gv = ACC_W'(prod_gv);
  assign ext_gu = ACC_W'(prod_gu);
  assign ext_b  = ACC_W'(prod_b);

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Form channel sums on each accepted request
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      frame_end_q <= frame_end;
      acc_r0      <= ys0 + ext_r;
      acc_g0      <= ys0 - ext_gv - ext_gu;
      acc_b0      <= ys0 + ext_b;
      acc_r1      <= ys1 + ext_r;
      acc_g1      <= ys1 - ext_gv - ext_gu;
      acc_b1      <= ys1 + ext_b;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/yrc_sat.sv =====
// ----------------------------------------------------------------------------
// yrc_sat
// Third pipeline stage: drop the fraction bits of each channel sum (floor)
// and clamp the result to 0..255.
// ----------------------------------------------------------------------------
`default_nettype none

module yrc_sat #(
  parameter int COEF_FRAC_BITS = yrc_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output      logic                              in_ready,
  input  wire logic                              frame_end,
  input  wire logic signed [COEF_FRAC_BITS+10:0] acc_r0,
  input  wire logic signed [COEF_FRAC_BITS+10:0] acc_g0,
  input  wire logic signed [COEF_FRAC_BITS+10:0] acc_b0,
  input  wire logic signed [COEF_FRAC_BITS+10:0] acc_r1,
  input  wire logic signed [COEF_FRAC_BITS+10:0] acc_g1,
  input  wire logic signed [COEF_FRAC_BITS+10:0] acc_b1,
  output      logic                              out_valid,
  input  wire logic                              out_ready,
  output      logic                              frame_end_q,
  output      yrc_pkg::rgb_pair_t                pix
);

  localparam int ACC_W = COEF_FRAC_BITS + yrc_pkg::CHAN_W;

  logic               valid;
  yrc_pkg::rgb_pair_t pix_next;

  // Integer part of each sum is the arithmetic shift right, then clamp
  always_comb begin
    pix_next.red0   = yrc_pkg::clamp_byte(acc_r0[ACC_W-1:COEF_FRAC_BITS]);
    pix_next.green0 = yrc_pkg::clamp_byte(acc_g0[ACC_W-1:COEF_FRAC_BITS]);
    pix_next.blue0  = yrc_pkg::clamp_byte(acc_b0[ACC_W-1:COEF_FRAC_BITS]);
    pix_next.red1   = yrc_pkg::clamp_byte(acc_r1[ACC_W-1:COEF_FRAC_BITS]);
    pix_next.green1 = yrc_pkg::clamp_byte(acc_g1[ACC_W-1:COEF_FRAC_BITS]);
    pix_next.blue1  = yrc_pkg::clamp_byte(acc_b1[ACC_W-1:COEF_FRAC_BITS]);
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Capture clamped pixels on each accepted request
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      frame_end_q <= frame_end;
      pix         <= pix_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/yrc_scale.sv =====
// ----------------------------------------------------------------------------
// yrc_scale
// Last pipeline stage and output register: scale each channel by 220/256
// and hold the result for the downstream side.
// ----------------------------------------------------------------------------
`default_nettype none

module yrc_scale (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic               frame_end,
  input  wire yrc_pkg::rgb_pair_t pix,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic               frame_end_q,
  output      yrc_pkg::rgb_pair_t pix_q
);

  logic               valid;
  yrc_pkg::rgb_pair_t pix_next;

  // Scale every channel
  always_comb begin
    pix_next.red0   = yrc_pkg::scale_byte(pix.red0);
    pix_next.green0 = yrc_pkg::scale_byte(pix.green0);
    pix_next.blue0  = yrc_pkg::scale_byte(pix.blue0);
    pix_next.red1   = yrc_pkg::scale_byte(pix.red1);
    pix_next.green1 = yrc_pkg::scale_byte(pix.green1);
    pix_next.blue1  = yrc_pkg::scale_byte(pix.blue1);
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Hold the result until the downstream side takes it
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      frame_end_q <= frame_end;
      pix_q       <= pix_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/yrc_checker.sv =====
// ----------------------------------------------------------------------------
// yrc_checker
// Port-level checks for the YUYV to RGB888 converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module yrc_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      s_tvalid,
  input wire logic                      s_tready,
  input wire logic [yrc_pkg::IN_W-1:0]  s_tdata,
  input wire logic                      s_tlast,
  input wire logic                      m_tvalid,
  input wire logic                      m_tready,
  input wire logic [yrc_pkg::OUT_W-1:0] m_tdata,
  input wire logic                      m_tlast
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // An open output lets the input flow
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input blocked while output is open");

  // Scaled channels never exceed 219
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:0] <= 8'd219) && (m_tdata[15:8] <= 8'd219) &&
                 (m_tdata[23:16] <= 8'd219) && (m_tdata[31:24] <= 8'd219) &&
                 (m_tdata[39:32] <= 8'd219) && (m_tdata[47:40] <= 8'd219))
    else $error("channel above scaled range");

endmodule

bind yuyv_to_rgb888_converter yrc_checker u_yrc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

`default_nettype wire
